// ===== hw/rtl/wpe_pkg.sv =====
package wpe_pkg;

	localparam int CORDIC_STAGES = 20;
	localparam int CW = 34;
	localparam int ZW = 33;
	localparam logic signed [CW-1:0] INV_GAIN = 34'sd652032874;
	localparam logic signed [36:0] DEG_TO_RAD = 37'sd19190098069;
	localparam logic signed [16:0] HALF_TURN = 17'sd11520;
	localparam logic signed [16:0] QUARTER_TURN = 17'sd5760;
	localparam logic signed [16:0] FULL_TURN = 17'sd23040;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_END   = 2'd1,
		MODE_MID   = 2'd2,
		MODE_KEEP  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0]         mode;
		logic [30:0]        length;
		logic signed [15:0] azimuth;
		logic signed [15:0] polar_angle;
		logic signed [31:0] start_x;
		logic signed [31:0] start_y;
		logic signed [31:0] start_z;
		logic signed [31:0] end_x;
		logic signed [31:0] end_y;
		logic signed [31:0] end_z;
	} req_t;

	typedef struct packed {
		logic signed [31:0] new_start_x;
		logic signed [31:0] new_start_y;
		logic signed [31:0] new_start_z;
		logic signed [31:0] new_end_x;
		logic signed [31:0] new_end_y;
		logic signed [31:0] new_end_z;
	} rsp_t;

	function automatic logic signed [ZW-1:0] atan_tab(input int i);
		logic signed [ZW-1:0] r;
		begin
			unique case (i)
				0: r = 33'sd843314857;
				1: r = 33'sd497837829;
				2: r = 33'sd263043837;
				3: r = 33'sd133525159;
				4: r = 33'sd67021687;
				5: r = 33'sd33543516;
				6: r = 33'sd16775851;
				7: r = 33'sd8388437;
				8: r = 33'sd4194283;
				9: r = 33'sd2097149;
				default: r = (i < 31) ? (33'sd1 <<< (30 - i)) : 33'sd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic signed [63:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

endpackage

// ===== hw/rtl/wpe_req_if.sv =====
interface wpe_req_if;
	import wpe_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/wpe_rsp_if.sv =====
interface wpe_rsp_if;
	import wpe_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== hw/rtl/wpe_angle.sv =====
module wpe_angle (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [15:0]           ang,
	output logic signed [wpe_pkg::ZW-1:0] z_s2,
	output logic                         flip_s2
);
	import wpe_pkg::*;
	logic signed [16:0] a, r;
	logic signed [16:0] r_s1;
	logic flip;
	logic flip_s1;
	logic signed [53:0] prod;

	always_comb begin
		a = 17'(ang);
		r = a;
		if (a >= HALF_TURN) r = a - FULL_TURN;
		else if (a < -HALF_TURN) r = a + FULL_TURN;
		flip = 1'b0;
		if (r > QUARTER_TURN) begin
			r = r - HALF_TURN;
			flip = 1'b1;
		end else if (r < -QUARTER_TURN) begin
			r = r + HALF_TURN;
			flip = 1'b1;
		end
		prod = 54'(r_s1) * 54'(DEG_TO_RAD) + 54'sd32768;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= r;
			flip_s1 <= flip;
			z_s2 <= ZW'(prod >>> 16);
			flip_s2 <= flip_s1;
		end
	end
endmodule

// ===== hw/rtl/wpe_cordic.sv =====
module wpe_cordic (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [wpe_pkg::ZW-1:0] z_in,
	input  logic                          flip_in,
	output logic signed [wpe_pkg::CW-1:0] sn,
	output logic signed [wpe_pkg::CW-1:0] cs
);
	import wpe_pkg::*;
	logic signed [CW-1:0] x_q [CORDIC_STAGES+1];
	logic signed [CW-1:0] y_q [CORDIC_STAGES+1];
	logic signed [ZW-1:0] z_q [CORDIC_STAGES+1];
	logic f_q [CORDIC_STAGES+1];

	assign x_q[0] = INV_GAIN;
	assign y_q[0] = '0;
	assign z_q[0] = z_in;
	assign f_q[0] = flip_in;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_st
		always_ff @(posedge clk) begin
			if (en) begin
				f_q[i+1] <= f_q[i];
				if (!z_q[i][ZW-1]) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - atan_tab(i);
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + atan_tab(i);
				end
			end
		end
	end

	assign sn = f_q[CORDIC_STAGES] ? -y_q[CORDIC_STAGES] : y_q[CORDIC_STAGES];
	assign cs = f_q[CORDIC_STAGES] ? -x_q[CORDIC_STAGES] : x_q[CORDIC_STAGES];
endmodule

// ===== hw/rtl/wire_polar_to_endpoints.sv =====
// channel | dir | payload
// req     | in  | mode, length, azimuth, polar_angle, start_xyz, end_xyz
// rsp     | out | new_start_xyz, new_end_xyz
// one request per cycle while the output is not held by a stall
// pipeline: angle reduce, radian multiply, cordic stages, two offset
// multiply stages, combine/saturate stage
// a stall freezes the whole pipeline; ready is low only when the output is held
// arst_n clears the valid bits only
module wire_polar_to_endpoints (
	input logic clk,
	input logic arst_n,
	wpe_req_if.sink   req,
	wpe_rsp_if.source rsp
);
	import wpe_pkg::*;
	localparam int LAT = CORDIC_STAGES + 5;

	logic en;
	logic [LAT-1:0] v_q;
	req_t d_q [LAT];
	logic signed [ZW-1:0] za, zp;
	logic fa, fp;
	logic signed [CW-1:0] sa, ca, sp, cp;
	logic signed [63:0] t_s1, dz_s1, dx_s2, dy_s2, dz_s2;
	logic signed [CW-1:0] sa_s1, ca_s1;
	rsp_t out_q;
	logic signed [63:0] s [3], e [3], d [3], ns [3], ne [3];

	assign en = !v_q[LAT-1] || rsp.ready;
	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LAT-2:0], req.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q[0] <= req.data;
			for (int k = 1; k < LAT; k++) d_q[k] <= d_q[k-1];
		end
	end

	wpe_angle u_aa (.clk, .en, .ang(req.data.azimuth), .z_s2(za), .flip_s2(fa));
	wpe_angle u_pa (.clk, .en, .ang(req.data.polar_angle), .z_s2(zp), .flip_s2(fp));
	wpe_cordic u_ca (.clk, .en, .z_in(za), .flip_in(fa), .sn(sa), .cs(ca));
	wpe_cordic u_cp (.clk, .en, .z_in(zp), .flip_in(fp), .sn(sp), .cs(cp));

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= (64'($signed({1'b0, d_q[CORDIC_STAGES+1].length})) * 64'(sp)
				+ 64'sd536870912) >>> 30;
			dz_s1 <= (64'($signed({1'b0, d_q[CORDIC_STAGES+1].length})) * 64'(cp)
				+ 64'sd536870912) >>> 30;
			sa_s1 <= sa;
			ca_s1 <= ca;
			dx_s2 <= (t_s1 * 64'(ca_s1) + 64'sd536870912) >>> 30;
			dy_s2 <= (t_s1 * 64'(sa_s1) + 64'sd536870912) >>> 30;
			dz_s2 <= dz_s1;
		end
	end

	always_comb begin
		s[0] = 64'(d_q[LAT-2].start_x);
		s[1] = 64'(d_q[LAT-2].start_y);
		s[2] = 64'(d_q[LAT-2].start_z);
		e[0] = 64'(d_q[LAT-2].end_x);
		e[1] = 64'(d_q[LAT-2].end_y);
		e[2] = 64'(d_q[LAT-2].end_z);
		d[0] = dx_s2;
		d[1] = dy_s2;
		d[2] = dz_s2;
		for (int k = 0; k < 3; k++) begin
			unique case (mode_t'(d_q[LAT-2].mode))
				MODE_START: begin
					ns[k] = s[k];
					ne[k] = s[k] + d[k];
				end
				MODE_END: begin
					ns[k] = e[k] - d[k];
					ne[k] = e[k];
				end
				MODE_MID: begin
					ns[k] = (s[k] + e[k] - d[k]) >>> 1;
					ne[k] = (s[k] + e[k] + d[k]) >>> 1;
				end
				default: begin
					ns[k] = s[k];
					ne[k] = e[k];
				end
			endcase
			ns[k] = sat32(ns[k]);
			ne[k] = sat32(ne[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.new_start_x <= ns[0][31:0];
			out_q.new_start_y <= ns[1][31:0];
			out_q.new_start_z <= ns[2][31:0];
			out_q.new_end_x   <= ne[0][31:0];
			out_q.new_end_y   <= ne[1][31:0];
			out_q.new_end_z   <= ne[2][31:0];
		end
	end

	assign rsp.valid = v_q[LAT-1];
	assign rsp.data  = out_q;

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp.valid |-> req.ready)
		else $error("ready low with empty output");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> $countones(v_q) <= LAT)
		else $error("valid count overflow");
`endif
endmodule

// ===== tb/sv/tb.sv =====
module tb;
	import wpe_pkg::*;

	logic clk;
	logic arst_n;

	wpe_req_if req_ch();
	wpe_rsp_if rsp_ch();

	wire_polar_to_endpoints u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch.sink),
		.rsp(rsp_ch.source)
	);

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES = 300;

	req_t req_pending[$];
	rsp_t endpoints_due[$];
	int n_sent;
	int n_checked;
	int n_errors;
	int phase;
	int hold_cnt;
	int idle_cycles;
	bit hold_done;
	bit req_taken;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void sin_cos(input longint ang, output longint sn, output longint cs);
		longint r;
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		longint at;
		bit flip;
		r = ang % 23040;
		flip = 1'b0;
		if (r >= 11520) r -= 23040;
		if (r < -11520) r += 23040;
		if (r > 5760) begin
			r -= 11520;
			flip = 1'b1;
		end else if (r < -5760) begin
			r += 11520;
			flip = 1'b1;
		end
		z = (r * 64'sd19190098069 + 64'sd32768) >>> 16;
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
			case (i)
				0: at = 843314857;
				1: at = 497837829;
				2: at = 263043837;
				3: at = 133525159;
				4: at = 67021687;
				5: at = 33543516;
				6: at = 16775851;
				7: at = 8388437;
				8: at = 4194283;
				9: at = 2097149;
				default: at = (i < 31) ? (64'sd1 <<< (30 - i)) : 64'sd0;
			endcase
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= at;
			end else begin
				x += dx;
				y -= dy;
				z += at;
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		sn = y;
		cs = x;
	endfunction

	function automatic logic [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return v[31:0];
	endfunction

	function automatic rsp_t place_wire(input req_t q);
		longint sa, ca, sp, cp, t, len;
		longint s[3], e[3], d[3], ns[3], ne[3];
		rsp_t o;
		len = longint'(q.length);
		s[0] = longint'(q.start_x); s[1] = longint'(q.start_y); s[2] = longint'(q.start_z);
		e[0] = longint'(q.end_x); e[1] = longint'(q.end_y); e[2] = longint'(q.end_z);
		sin_cos(longint'(q.azimuth), sa, ca);
		sin_cos(longint'(q.polar_angle), sp, cp);
		t = (len * sp + (64'sd1 <<< 29)) >>> 30;
		d[0] = (t * ca + (64'sd1 <<< 29)) >>> 30;
		d[1] = (t * sa + (64'sd1 <<< 29)) >>> 30;
		d[2] = (len * cp + (64'sd1 <<< 29)) >>> 30;
		for (int k = 0; k < 3; k++) begin
			case (mode_t'(q.mode))
				MODE_START: begin
					ns[k] = s[k];
					ne[k] = s[k] + d[k];
				end
				MODE_END: begin
					ne[k] = e[k];
					ns[k] = e[k] - d[k];
				end
				MODE_MID: begin
					ns[k] = (s[k] + e[k] - d[k]) >>> 1;
					ne[k] = (s[k] + e[k] + d[k]) >>> 1;
				end
				default: begin
					ns[k] = s[k];
					ne[k] = e[k];
				end
			endcase
		end
		o.new_start_x = clamp32(ns[0]);
		o.new_start_y = clamp32(ns[1]);
		o.new_start_z = clamp32(ns[2]);
		o.new_end_x = clamp32(ne[0]);
		o.new_end_y = clamp32(ne[1]);
		o.new_end_z = clamp32(ne[2]);
		return o;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 65535)
				: 32'h80000000 + $urandom_range(0, 65535);
			1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_angle();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(0, 16)) * 1440 - 11520);
			default: return 16'($signed($urandom_range(0, 46080)) - 23040);
		endcase
	endfunction

	task automatic add_item(input logic [1:0] m, input logic [30:0] l, input logic [15:0] az,
			input logic [15:0] pa, input logic [31:0] c0, input logic [31:0] c1);
		req_t q;
		q.mode = m;
		q.length = l;
		q.azimuth = az;
		q.polar_angle = pa;
		q.start_x = c0;
		q.start_y = c0 ^ 32'h5a5a5a5a;
		q.start_z = ~c0;
		q.end_x = c1;
		q.end_y = c1 ^ 32'ha5a5a5a5;
		q.end_z = ~c1;
		req_pending.push_back(q);
	endtask

	// driver
	always @(negedge clk) begin
		int idle_pct;
		idle_pct = (phase == 1) ? 88 : ((phase == 3) ? 26 : 0);
		if (arst_n && (!req_ch.valid || req_taken)) begin
			if (req_pending.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
				req_ch.data <= req_pending.pop_front();
				req_ch.valid <= 1'b1;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			rsp_ch.ready <= 1'b0;
		end else if (!hold_done && n_sent >= 950) begin
			hold_done <= 1'b1;
			hold_cnt <= HOLD_CYCLES;
			rsp_ch.ready <= 1'b0;
		end else if (phase == 2) begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= 88);
		end else if (phase == 3) begin
			rsp_ch.ready <= ($urandom_range(0, 99) >= 26);
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t got;
		rsp_t want;
		logic [31:0] gv[6];
		logic [31:0] wv[6];
		string fname[6];
		req_taken = req_ch.valid && req_ch.ready;
		if (arst_n) begin
			if (req_taken) begin
				endpoints_due.push_back(place_wire(req_ch.data));
				n_sent++;
				if (n_sent == 300) phase = 1;
				else if (n_sent == 450) phase = 2;
				else if (n_sent == 650) phase = 3;
				else if (n_sent == 850) phase = 0;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = rsp_ch.data;
				if (endpoints_due.size() == 0) begin
					$error("response with nothing outstanding");
					n_errors++;
				end else begin
					want = endpoints_due.pop_front();
					fname = '{"new_start_x", "new_start_y", "new_start_z",
						"new_end_x", "new_end_y", "new_end_z"};
					gv = '{got.new_start_x, got.new_start_y, got.new_start_z,
						got.new_end_x, got.new_end_y, got.new_end_z};
					wv = '{want.new_start_x, want.new_start_y, want.new_start_z,
						want.new_end_x, want.new_end_y, want.new_end_z};
					for (int k = 0; k < 6; k++) begin
						if (gv[k] !== wv[k]) begin
							$error("%s expected %0d got %0d", fname[k],
								$signed(wv[k]), $signed(gv[k]));
							n_errors++;
						end
					end
				end
				n_checked++;
			end
			if (req_taken || (rsp_ch.valid && rsp_ch.ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		rsp_ch.ready = 1'b0;
		n_sent = 0;
		n_checked = 0;
		n_errors = 0;
		phase = 0;
		hold_cnt = 0;
		hold_done = 1'b0;
		idle_cycles = 0;
		req_taken = 1'b0;

		// directed
		add_item(MODE_START, 31'd65536, 16'sd0, 16'sd0, 32'd0, 32'd0);
		add_item(MODE_END, 31'd65536, 16'sd5760, 16'sd5760, 32'd100, 32'd200);
		add_item(MODE_MID, 31'd131072, 16'sd2880, 16'sd2880, 32'h00010000, 32'hffff0000);
		add_item(MODE_KEEP, 31'h7fffffff, 16'sd1000, 16'sd2000, 32'h12345678, 32'h87654321);
		add_item(MODE_START, 31'd0, 16'sd3000, 16'sd4000, 32'h7fffffff, 32'h80000000);
		add_item(MODE_MID, 31'd0, 16'sd3000, 16'sd4000, 32'h7fffffff, 32'h7fffffff);
		add_item(MODE_START, 31'd1, 16'sd23040, -16'sd23040, 32'd5, 32'd7);
		add_item(MODE_START, 31'h7fffffff, 16'sd0, 16'sd5760, 32'h7fffffff, 32'd0);
		add_item(MODE_START, 31'h7fffffff, 16'sd11520, 16'sd5760, 32'h80000000, 32'd0);
		add_item(MODE_END, 31'h7fffffff, 16'sd0, 16'sd0, 32'd0, 32'h80000000);
		add_item(MODE_END, 31'h7fffffff, 16'sd0, 16'sd11520, 32'd0, 32'h7fffffff);
		add_item(MODE_MID, 31'h7fffffff, -16'sd5760, 16'sd5761, 32'h80000000, 32'h80000000);
		add_item(MODE_MID, 31'h7fffffff, 16'sd11519, -16'sd5761, 32'h7fffffff, 32'h7fffffff);
		add_item(MODE_START, 31'd1000000, -16'sd11520, -16'sd11520, 32'd0, 32'd0);
		add_item(MODE_END, 31'd1000000, 16'sd17280, -16'sd17280, 32'd0, 32'd0);
		add_item(MODE_START, 31'd1000000, 16'h8000, 16'h7fff, 32'd0, 32'd0);
		add_item(MODE_MID, 31'd1000000, 16'hffff, 16'h0001, 32'hffffffff, 32'd1);
		add_item(MODE_KEEP, 31'd0, 16'h8000, 16'h8000, 32'h80000000, 32'h7fffffff);
		add_item(MODE_START, 31'h40000000, 16'sd23039, 16'sd12000, 32'h00001234, 32'd0);

		for (int i = 0; i < 1050; i++) begin
			req_t q;
			q.mode = ($urandom_range(0, 15) == 0) ? 2'(MODE_KEEP) : 2'($urandom_range(0, 2));
			case ($urandom_range(0, 3))
				0: q.length = 31'($urandom_range(1, 32'h00100000));
				1: q.length = 31'(32'h7fffffff - $urandom_range(0, 1000));
				default: q.length = 31'($urandom);
			endcase
			q.azimuth = rand_angle();
			q.polar_angle = rand_angle();
			q.start_x = rand_coord();
			q.start_y = rand_coord();
			q.start_z = rand_coord();
			q.end_x = rand_coord();
			q.end_y = rand_coord();
			q.end_z = rand_coord();
			req_pending.push_back(q);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_pending.size() != 0 || req_ch.valid || endpoints_due.size() != 0)
			@(posedge clk);
		repeat (CORDIC_STAGES + 20) @(posedge clk);
		$display("covered %0d requests, %0d responses checked, over all anchor modes,",
			n_sent, n_checked);
		$display("angle wrap and saturation, with sender gaps, receiver stalls and a long hold-off");
		if (n_errors == 0 && endpoints_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
